// ===== hw/rtl/rms_pkg.sv =====
package rms_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 16;
    localparam int FUNC_W         = 2;

    // operation codes of an input beat
    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_ERASE  = 2'd1,
        FUNC_CLEAR  = 2'd2
    } t_func;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_INS_READ,
        OP_INS_SHIFT,
        OP_INS_PUT,
        OP_ERS_READ,
        OP_ERS_STEP,
        OP_ERS_END,
        OP_MED_LO,
        OP_MED_HI,
        OP_MED_CAP,
        OP_OUT_LOAD
    } t_dp_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_RD,
        S_INS_CMP,
        S_ERS_RD,
        S_ERS_CMP,
        S_ERS_END,
        S_MED_LO,
        S_MED_HI,
        S_MED_CAP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic   take_in;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic              in_valid;
        logic [FUNC_W-1:0] func;
        logic              count_full;
        logic              count_zero;
        logic              ptr_zero;
        logic              ptr_end;
        logic              rd_gt;
        logic              out_free;
    } t_dp_stat;

endpackage

// ===== hw/rtl/rms_in_if.sv =====
interface rms_in_if
    import rms_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic        [FUNC_W-1:0]     func;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

// ===== hw/rtl/rms_out_if.sv =====
interface rms_out_if
    import rms_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int CNT_W      = $clog2(CAPACITY_DEF + 1)
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] lower_median;
    logic signed [VALUE_BITS-1:0] upper_median;
    logic signed [VALUE_BITS-1:0] mean_median;
    logic                         median_valid;
    logic        [CNT_W-1:0]      element_count;
    logic                         erase_found;
    logic                         insert_accepted;

    modport source (
        output valid, output lower_median, output upper_median, output mean_median,
        output median_valid, output element_count, output erase_found,
        output insert_accepted, input ready
    );
    modport sink (
        input valid, input lower_median, input upper_median, input mean_median,
        input median_valid, input element_count, input erase_found,
        input insert_accepted, output ready
    );
endinterface

// ===== hw/rtl/running_median_sorted_store_unit.sv =====
// One beat at a time: an insert into a store that is not full moves each larger entry up
// one place, and an erase reads every stored entry and moves those after the match down one;
// then, for every operation, both medians are read unless the store is empty. The next beat
// is taken only after its result is loaded, later while a waiting result holds the output register.
// Synchronous active-low reset empties the store (count 0); contents stay unwritten.
module running_median_sorted_store_unit
    import rms_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    rms_in_if.sink    i_in,
    rms_out_if.source o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    rms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    rms_datapath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

// ===== hw/rtl/rms_ctrl.sv =====
module rms_ctrl
    import rms_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.take_in = 1'b0;
        o_cmd.op      = OP_NONE;
        case (r_state)
            S_IDLE: begin
                o_cmd.take_in = 1'b1;
                if (i_stat.in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.func)
                    FUNC_INSERT: begin
                        n_state = i_stat.count_full ? S_MED_LO : S_INS_RD;
                    end
                    FUNC_ERASE: begin
                        n_state = S_ERS_RD;
                    end
                    FUNC_CLEAR: begin
                        o_cmd.op = OP_CLEAR;
                        n_state  = S_MED_LO;
                    end
                    default: begin
                        n_state = S_MED_LO;
                    end
                endcase
            end
            S_INS_RD: begin
                // bottom of the store reached: the value goes at index 0
                if (i_stat.ptr_zero) begin
                    o_cmd.op = OP_INS_PUT;
                    n_state  = S_MED_LO;
                end else begin
                    o_cmd.op = OP_INS_READ;
                    n_state  = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_stat.rd_gt) begin
                    o_cmd.op = OP_INS_SHIFT;
                    n_state  = S_INS_RD;
                end else begin
                    o_cmd.op = OP_INS_PUT;
                    n_state  = S_MED_LO;
                end
            end
            S_ERS_RD: begin
                if (i_stat.ptr_end) begin
                    n_state = S_ERS_END;
                end else begin
                    o_cmd.op = OP_ERS_READ;
                    n_state  = S_ERS_CMP;
                end
            end
            S_ERS_CMP: begin
                o_cmd.op = OP_ERS_STEP;
                n_state  = S_ERS_RD;
            end
            S_ERS_END: begin
                o_cmd.op = OP_ERS_END;
                n_state  = S_MED_LO;
            end
            S_MED_LO: begin
                if (i_stat.count_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_MED_LO;
                    n_state  = S_MED_HI;
                end
            end
            S_MED_HI: begin
                o_cmd.op = OP_MED_HI;
                n_state  = S_MED_CAP;
            end
            S_MED_CAP: begin
                o_cmd.op = OP_MED_CAP;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_OUT_LOAD;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/rms_datapath.sv =====
module rms_datapath
    import rms_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    rms_in_if.sink   i_in,
    rms_out_if.source o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    logic signed [VALUE_BITS-1:0] r_mem [CAPACITY];
    logic signed [VALUE_BITS-1:0] r_rd_data;

    logic        [CNT_W-1:0]      r_count;
    logic        [CNT_W-1:0]      n_count;
    logic        [CNT_W-1:0]      r_ptr;
    logic        [CNT_W-1:0]      n_ptr;
    logic                         r_found;
    logic                         n_found;
    logic                         r_accepted;
    logic                         n_accepted;
    logic        [FUNC_W-1:0]     r_func;
    logic signed [VALUE_BITS-1:0] r_value;
    logic signed [VALUE_BITS-1:0] r_lo;
    logic signed [VALUE_BITS-1:0] r_hi;

    logic                         r_out_valid;
    logic signed [VALUE_BITS-1:0] r_out_lo;
    logic signed [VALUE_BITS-1:0] r_out_hi;
    logic signed [VALUE_BITS-1:0] r_out_mean;
    logic                         r_out_mvalid;
    logic        [CNT_W-1:0]      r_out_count;
    logic                         r_out_found;
    logic                         r_out_accepted;

    logic                         in_take;
    logic        [CNT_W-1:0]      ptr_m1;
    logic        [CNT_W-1:0]      cnt_m1;
    logic        [CNT_W-1:0]      lo_pos;
    logic        [CNT_W-1:0]      hi_pos;
    logic                         mem_we;
    logic        [IDX_W-1:0]      mem_waddr;
    logic signed [VALUE_BITS-1:0] mem_wdata;
    logic        [IDX_W-1:0]      mem_raddr;
    logic signed [VALUE_BITS:0]   med_sum;
    logic signed [VALUE_BITS:0]   med_sum_adj;
    logic signed [VALUE_BITS:0]   med_half;
    logic                         count_zero;

    assign in_take    = i_cmd.take_in && i_in.valid;
    assign i_in.ready = i_cmd.take_in;

    assign ptr_m1     = r_ptr - 1'b1;
    assign cnt_m1     = r_count - 1'b1;
    assign lo_pos     = cnt_m1 >> 1;
    assign hi_pos     = r_count >> 1;
    assign count_zero = (r_count == '0);

    // mean from a sum one bit wider, rounded toward zero
    assign med_sum     = {r_lo[VALUE_BITS-1], r_lo} + {r_hi[VALUE_BITS-1], r_hi};
    assign med_sum_adj = med_sum + {{VALUE_BITS{1'b0}}, med_sum[VALUE_BITS]};
    assign med_half    = med_sum_adj >>> 1;

    assign o_stat.in_valid   = i_in.valid;
    assign o_stat.func       = r_func;
    assign o_stat.count_full = (r_count == CNT_W'(CAPACITY));
    assign o_stat.count_zero = count_zero;
    assign o_stat.ptr_zero   = (r_ptr == '0);
    assign o_stat.ptr_end    = (r_ptr == r_count);
    assign o_stat.rd_gt      = (r_rd_data > r_value);
    assign o_stat.out_free   = !r_out_valid || o_out.ready;

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ptr[IDX_W-1:0];
        mem_wdata = r_rd_data;
        mem_raddr = r_ptr[IDX_W-1:0];
        case (i_cmd.op)
            OP_INS_READ: begin
                mem_raddr = ptr_m1[IDX_W-1:0];
            end
            OP_INS_SHIFT: begin
                mem_we = 1'b1;
            end
            OP_INS_PUT: begin
                mem_we    = 1'b1;
                mem_wdata = r_value;
            end
            OP_ERS_STEP: begin
                // once the match is gone, every later entry moves down one
                mem_we    = r_found;
                mem_waddr = ptr_m1[IDX_W-1:0];
            end
            OP_MED_LO: begin
                mem_raddr = lo_pos[IDX_W-1:0];
            end
            OP_MED_HI: begin
                mem_raddr = hi_pos[IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_comb begin
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_found    = r_found;
        n_accepted = r_accepted;
        if (in_take) begin
            n_found    = 1'b0;
            n_accepted = 1'b0;
            n_ptr      = (i_in.func == FUNC_INSERT) ? r_count : '0;
        end
        case (i_cmd.op)
            OP_CLEAR: begin
                n_count = '0;
            end
            OP_INS_SHIFT: begin
                n_ptr = ptr_m1;
            end
            OP_INS_PUT: begin
                n_count    = r_count + 1'b1;
                n_accepted = 1'b1;
            end
            OP_ERS_STEP: begin
                n_ptr = r_ptr + 1'b1;
                if (!r_found && (r_rd_data == r_value)) begin
                    n_found = 1'b1;
                end
            end
            OP_ERS_END: begin
                if (r_found) begin
                    n_count = cnt_m1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.op == OP_OUT_LOAD) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_found    <= n_found;
        r_accepted <= n_accepted;
        if (in_take) begin
            r_func  <= i_in.func;
            r_value <= i_in.value;
        end
        if (i_cmd.op == OP_MED_HI) begin
            r_lo <= r_rd_data;
        end
        if (i_cmd.op == OP_MED_CAP) begin
            r_hi <= r_rd_data;
        end
        if (i_cmd.op == OP_OUT_LOAD) begin
            r_out_lo       <= count_zero ? '0 : r_lo;
            r_out_hi       <= count_zero ? '0 : r_hi;
            r_out_mean     <= count_zero ? '0 : med_half[VALUE_BITS-1:0];
            r_out_mvalid   <= !count_zero;
            r_out_count    <= r_count;
            r_out_found    <= r_found;
            r_out_accepted <= r_accepted;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.lower_median    = r_out_lo;
    assign o_out.upper_median    = r_out_hi;
    assign o_out.mean_median     = r_out_mean;
    assign o_out.median_valid    = r_out_mvalid;
    assign o_out.element_count   = r_out_count;
    assign o_out.erase_found     = r_out_found;
    assign o_out.insert_accepted = r_out_accepted;

endmodule

// ===== tb/tb_running_median_sorted_store_unit.sv =====
`timescale 1ns / 1ps

module tb_running_median_sorted_store_unit;
    import rms_pkg::*;

    localparam int VW               = VALUE_BITS_DEF;
    localparam int CW               = $clog2(CAPACITY_DEF + 1);
    localparam int RANDOM_BEATS     = 900;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int DRAIN_CYCLES     = 200;

    // func code with no operation behind it
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [VW-1:0] lower;
        logic signed [VW-1:0] upper;
        logic signed [VW-1:0] mean;
        logic                 valid;
        logic [CW-1:0]        count;
        logic                 found;
        logic                 accepted;
    } t_median_report;

    typedef struct packed {
        logic [FUNC_W-1:0]    op;
        logic signed [VW-1:0] val;
        logic                 known;
        t_median_report       rpt;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    rms_in_if  beat_in ();
    rms_out_if beat_out ();

    running_median_sorted_store_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (beat_in),
        .o_out   (beat_out)
    );

    // shadow copy of the sorted store
    logic signed [VW-1:0] shadow_store [CAPACITY_DEF];
    int                   shadow_count;

    t_median_report report_q [$];
    t_stim_row      dir_rows [$];

    // typed expectation riding along with the beat on the input
    logic           row_is_typed;
    t_median_report row_report;

    int  src_idle_pct;
    int  sink_idle_pct;
    logic hold_off_req;

    int error_count;
    int beats_in;
    int reports_out;
    int stall_cycles;
    int full_drops;
    int erase_misses;
    int clears_seen;
    int peak_count;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_median_report report_of(
        input logic signed [VW-1:0] lower,
        input logic signed [VW-1:0] upper,
        input logic signed [VW-1:0] mean,
        input logic                 valid,
        input int                   count,
        input logic                 found,
        input logic                 accepted
    );
        t_median_report r;
        r.lower    = lower;
        r.upper    = upper;
        r.mean     = mean;
        r.valid    = valid;
        r.count    = count[CW-1:0];
        r.found    = found;
        r.accepted = accepted;
        return r;
    endfunction

    function automatic t_stim_row row_plain(
        input logic [FUNC_W-1:0] op, input logic signed [VW-1:0] val
    );
        t_stim_row r;
        r.op    = op;
        r.val   = val;
        r.known = 1'b0;
        r.rpt   = '0;
        return r;
    endfunction

    function automatic t_stim_row row_known(
        input logic [FUNC_W-1:0] op, input logic signed [VW-1:0] val,
        input t_median_report rpt
    );
        t_stim_row r;
        r       = row_plain(op, val);
        r.known = 1'b1;
        r.rpt   = rpt;
        return r;
    endfunction

    // applies one operation to the shadow store, returns the report it yields
    function automatic t_median_report step_median_store(
        input logic [FUNC_W-1:0] op, input logic signed [VW-1:0] val
    );
        t_median_report       r;
        logic signed [VW:0]   pair_sum;
        logic                 hit;
        int                   pos;
        int                   idx;
        r = '0;
        case (op)
            FUNC_INSERT: begin
                if (shadow_count >= CAPACITY_DEF) begin
                    full_drops++;
                end else begin
                    // lands after any equal entries
                    pos = shadow_count;
                    while (pos > 0 && shadow_store[pos-1] > val) begin
                        shadow_store[pos] = shadow_store[pos-1];
                        pos--;
                    end
                    shadow_store[pos] = val;
                    shadow_count++;
                    r.accepted = 1'b1;
                end
            end
            FUNC_ERASE: begin
                hit = 1'b0;
                for (idx = 0; idx < shadow_count && !hit; idx++) begin
                    if (shadow_store[idx] == val) begin
                        for (pos = idx; pos + 1 < shadow_count; pos++)
                            shadow_store[pos] = shadow_store[pos+1];
                        shadow_count--;
                        hit = 1'b1;
                    end
                end
                r.found = hit;
                if (!hit)
                    erase_misses++;
            end
            FUNC_CLEAR: begin
                shadow_count = 0;
                clears_seen++;
            end
            default: ;
        endcase
        if (shadow_count > 0) begin
            r.lower  = shadow_store[(shadow_count - 1) / 2];
            r.upper  = shadow_store[shadow_count / 2];
            pair_sum = r.lower + r.upper;
            r.mean   = VW'(pair_sum / 17'sd2);
            r.valid  = 1'b1;
        end
        r.count = shadow_count[CW-1:0];
        if (shadow_count > peak_count)
            peak_count = shadow_count;
        return r;
    endfunction

    task automatic note_mismatch(input string field, input int want, input int got);
        error_count++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    task automatic check_report(input t_median_report want, input t_median_report seen);
        if (seen.lower !== want.lower)
            note_mismatch("lower_median", int'(want.lower), int'(seen.lower));
        if (seen.upper !== want.upper)
            note_mismatch("upper_median", int'(want.upper), int'(seen.upper));
        if (seen.mean !== want.mean)
            note_mismatch("mean_median", int'(want.mean), int'(seen.mean));
        if (seen.valid !== want.valid)
            note_mismatch("median_valid", int'(want.valid), int'(seen.valid));
        if (seen.count !== want.count)
            note_mismatch("element_count", int'(want.count), int'(seen.count));
        if (seen.found !== want.found)
            note_mismatch("erase_found", int'(want.found), int'(seen.found));
        if (seen.accepted !== want.accepted)
            note_mismatch("insert_accepted", int'(want.accepted), int'(seen.accepted));
    endtask

    always @(posedge i_clk) begin
        t_median_report seen;
        t_median_report want;
        logic           moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (beat_out.valid && beat_out.ready) begin
                moved          = 1'b1;
                reports_out++;
                seen.lower     = beat_out.lower_median;
                seen.upper     = beat_out.upper_median;
                seen.mean      = beat_out.mean_median;
                seen.valid     = beat_out.median_valid;
                seen.count     = beat_out.element_count;
                seen.found     = beat_out.erase_found;
                seen.accepted  = beat_out.insert_accepted;
                if (report_q.size() == 0) begin
                    error_count++;
                    $display("%0t: report with nothing expected, got count %0d lower %0d",
                             $time, seen.count, seen.lower);
                end else begin
                    check_report(report_q.pop_front(), seen);
                end
            end
            if (beat_in.valid && beat_in.ready) begin
                moved = 1'b1;
                beats_in++;
                want  = step_median_store(beat_in.func, beat_in.value);
                report_q.push_back(row_is_typed ? row_report : want);
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("[running_median_sorted_store_unit] ERROR");
                $finish;
            end
        end
    end

    // sink side
    initial begin
        beat_out.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                // park the output so the unit fills up and stalls its input
                beat_out.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end
            beat_out.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic send_beat(input t_stim_row r);
        while ($urandom_range(99) < src_idle_pct) begin
            beat_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        beat_in.valid <= 1'b1;
        beat_in.func  <= r.op;
        beat_in.value <= r.val;
        row_is_typed  <= r.known;
        row_report    <= r.rpt;
        @(posedge i_clk);
        while (!beat_in.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic signed [VW-1:0] pick_value();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1:       return $urandom_range(1) ? -16'sd1 : 16'sd0;
            2, 3, 4: return VW'($urandom_range(15)) - 16'sd8;
            default: return VW'($urandom);
        endcase
    endfunction

    initial begin
        t_median_report none;
        t_stim_row      r;
        int             mode;
        int             burst;
        int             ins_pct;
        int             roll;
        int             sent;

        none          = '0;
        i_rst_n       = 1'b0;
        beat_in.valid = 1'b0;
        beat_in.func  = FUNC_INSERT;
        beat_in.value = '0;
        row_is_typed  = 1'b0;
        row_report    = '0;
        src_idle_pct  = 9;
        sink_idle_pct = 63;
        hold_off_req  = 1'b0;
        error_count   = 0;
        beats_in      = 0;
        reports_out   = 0;
        stall_cycles  = 0;
        full_drops    = 0;
        erase_misses  = 0;
        clears_seen   = 0;
        peak_count    = 0;
        shadow_count  = 0;

        dir_rows.push_back(row_known(FUNC_ERASE, 16'sd5, none));
        dir_rows.push_back(row_known(FUNC_UNUSED, 16'sd0, none));
        dir_rows.push_back(row_known(FUNC_CLEAR, 16'sd0, none));
        dir_rows.push_back(row_known(FUNC_INSERT, 16'sh8000,
            report_of(16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 1, 1'b0, 1'b1)));
        // extremes together: mean of -32768 and 32767 truncates to 0
        dir_rows.push_back(row_known(FUNC_INSERT, 16'sh7FFF,
            report_of(16'sh8000, 16'sh7FFF, 16'sd0, 1'b1, 2, 1'b0, 1'b1)));
        dir_rows.push_back(row_known(FUNC_INSERT, 16'sh7FFF,
            report_of(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 3, 1'b0, 1'b1)));
        dir_rows.push_back(row_known(FUNC_ERASE, 16'sh8000,
            report_of(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 2, 1'b1, 1'b0)));
        dir_rows.push_back(row_known(FUNC_ERASE, 16'sd0,
            report_of(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 2, 1'b0, 1'b0)));
        dir_rows.push_back(row_known(FUNC_UNUSED, 16'sh5555,
            report_of(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 2, 1'b0, 1'b0)));
        dir_rows.push_back(row_known(FUNC_CLEAR, 16'sh7FFF, none));
        dir_rows.push_back(row_known(FUNC_INSERT, -16'sd1,
            report_of(-16'sd1, -16'sd1, -16'sd1, 1'b1, 1, 1'b0, 1'b1)));
        // -3/2 rounds toward zero
        dir_rows.push_back(row_known(FUNC_INSERT, -16'sd2,
            report_of(-16'sd2, -16'sd1, -16'sd1, 1'b1, 2, 1'b0, 1'b1)));
        dir_rows.push_back(row_plain(FUNC_INSERT, 16'sd1));
        dir_rows.push_back(row_plain(FUNC_INSERT, 16'sd2));
        dir_rows.push_back(row_plain(FUNC_INSERT, 16'sd1));
        dir_rows.push_back(row_plain(FUNC_ERASE, 16'sd1));
        dir_rows.push_back(row_plain(FUNC_ERASE, 16'sd1));
        dir_rows.push_back(row_plain(FUNC_ERASE, 16'sd1));
        dir_rows.push_back(row_plain(FUNC_INSERT, 16'sh7FFF));
        dir_rows.push_back(row_plain(FUNC_INSERT, 16'sh7FFE));
        dir_rows.push_back(row_plain(FUNC_INSERT, 16'sh8000));
        dir_rows.push_back(row_plain(FUNC_ERASE, -16'sd2));
        dir_rows.push_back(row_plain(FUNC_INSERT, 16'sh5555));
        dir_rows.push_back(row_plain(FUNC_INSERT, 16'shAAAA));
        dir_rows.push_back(row_known(FUNC_CLEAR, 16'shAAAA, none));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k])
            send_beat(dir_rows[k]);

        sent = 0;
        while (sent < RANDOM_BEATS) begin
            // bursts that fill, drain, or churn the store
            mode    = $urandom_range(2);
            burst   = $urandom_range(40, 100);
            ins_pct = (mode == 0) ? 90 : (mode == 1) ? 22 : 50;
            for (int b = 0; b < burst && sent < RANDOM_BEATS; b++) begin
                if (sent == RANDOM_BEATS / 3) begin
                    src_idle_pct  = 63;
                    sink_idle_pct = 9;
                end else if (sent == 2 * RANDOM_BEATS / 3) begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                    hold_off_req  = 1'b1;
                end
                roll = $urandom_range(99);
                if (roll < 1)
                    r = row_plain(FUNC_CLEAR, VW'($urandom));
                else if (roll < 3)
                    r = row_plain(FUNC_UNUSED, VW'($urandom));
                else if (roll < 3 + ins_pct)
                    r = row_plain(FUNC_INSERT, pick_value());
                else if (shadow_count > 0 && $urandom_range(3) != 0)
                    r = row_plain(FUNC_ERASE,
                                  shadow_store[$urandom_range(shadow_count - 1)]);
                else
                    r = row_plain(FUNC_ERASE, pick_value());
                send_beat(r);
                sent++;
            end
        end

        beat_in.valid <= 1'b0;
        row_is_typed  <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d beats (%0d table rows), %0d reports, peak occupancy %0d of %0d",
                 beats_in, dir_rows.size(), reports_out, peak_count, CAPACITY_DEF);
        $display("  %0d inserts dropped when full, %0d erases without a match, %0d clears",
                 full_drops, erase_misses, clears_seen);
        if (error_count == 0)
            $display("[running_median_sorted_store_unit] OK");
        else
            $display("[running_median_sorted_store_unit] ERROR");
        $finish;
    end

endmodule
